FILE: rtl/core/frustum_cull_and_classify_defines.svh
// ----------------------------------------------------------------------
// frustum_cull_and_classify_defines: assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------
`ifndef FRUSTUM_CULL_AND_CLASSIFY_DEFINES_SVH
`define FRUSTUM_CULL_AND_CLASSIFY_DEFINES_SVH

// same-cycle implication
`define FRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/frs_pkg.sv
// ----------------------------------------------------------------------
// frs_pkg: shared types and constants
// plane layout, command and side codes, register indexes
// ----------------------------------------------------------------------
package frs_pkg;

  localparam int NORM_BITS     = 16;
  localparam int Q_SHIFT       = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int TOL_BITS      = 16;
  localparam int COUNT_BITS    = 3;
  localparam int SEL_BITS      = 3;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_BOX_CULL    = 2'd0;
  localparam cmd_t CMD_SPHERE_CULL = 2'd1;
  localparam cmd_t CMD_CLASSIFY    = 2'd2;

  typedef logic [1:0] side_t;
  localparam side_t SIDE_ON     = 2'd0;
  localparam side_t SIDE_BEHIND = 2'd1;
  localparam side_t SIDE_FRONT  = 2'd2;

  typedef logic [CFG_IDX_BITS-1:0] reg_idx_t;
  localparam reg_idx_t REG_PLANES_IN_USE = 3'd6;
  localparam reg_idx_t REG_EDGE_TOL      = 3'd7;

  localparam logic [COUNT_BITS-1:0] RESET_IN_USE = 3'd6;
  localparam logic [TOL_BITS-1:0]   RESET_TOL    = 16'd2;

  // normal in Q2.14, offset in integer units
  typedef struct packed {
    logic signed [NORM_BITS-1:0] nx;
    logic signed [NORM_BITS-1:0] ny;
    logic signed [NORM_BITS-1:0] nz;
    logic signed [NORM_BITS-1:0] off;
  } plane_t;

  typedef struct packed {
    cmd_t                cmd;
    logic                shape_null;
    logic [SEL_BITS-1:0] plane_select;
  } ctl_t;

endpackage

FILE: rtl/core/frs_cfg_regs.sv
// ----------------------------------------------------------------------
// frs_cfg_regs: configuration register file
// plane registers, plane count (clamped on read) and classify tolerance
// ----------------------------------------------------------------------
module frs_cfg_regs #(
  parameter int PLANE_COUNT = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [frs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [frs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output frs_pkg::plane_t                     planes [PLANE_COUNT],
  output logic [frs_pkg::COUNT_BITS-1:0]      used_count,
  output logic [frs_pkg::TOL_BITS-1:0]        edge_tol
);
  import frs_pkg::*;

  localparam logic [COUNT_BITS-1:0] PLANE_MAX = COUNT_BITS'(PLANE_COUNT);

  plane_t                planes_r [PLANE_COUNT];
  logic [COUNT_BITS-1:0] in_use_r;
  logic [TOL_BITS-1:0]   tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes_r[i] <= '0;
      end
      in_use_r <= RESET_IN_USE;
      tol_r    <= RESET_TOL;
    end else if (cfg_we) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (cfg_index == CFG_IDX_BITS'(i)) begin
          planes_r[i] <= plane_t'(cfg_data);
        end
      end
      if (cfg_index == REG_PLANES_IN_USE) begin
        in_use_r <= cfg_data[COUNT_BITS-1:0];
      end
      if (cfg_index == REG_EDGE_TOL) begin
        tol_r <= cfg_data[TOL_BITS-1:0];
      end
    end
  end

  assign planes     = planes_r;
  assign used_count = (in_use_r > PLANE_MAX) ? PLANE_MAX : in_use_r;
  assign edge_tol   = tol_r;

endmodule

FILE: rtl/core/frs_product_stage.sv
// ----------------------------------------------------------------------
// frs_product_stage: corner selection and registered products
// one product per plane and axis for the cull tests, plus the extreme
// corner products of the selected plane for classify
// ----------------------------------------------------------------------
module frs_product_stage #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 16
) (
  input  logic                                           clk,
  input  logic                                           advance,
  input  frs_pkg::plane_t                                planes [PLANE_COUNT],
  input  frs_pkg::ctl_t                                  ctl,
  input  logic signed [COORD_BITS-1:0]                   lo [3],
  input  logic signed [COORD_BITS-1:0]                   hi [3],
  output logic signed [frs_pkg::NORM_BITS+COORD_BITS-1:0] cull_prod_r [PLANE_COUNT][3],
  output logic signed [frs_pkg::NORM_BITS+COORD_BITS-1:0] min_prod_r [3],
  output logic signed [frs_pkg::NORM_BITS+COORD_BITS-1:0] max_prod_r [3],
  output logic signed [frs_pkg::NORM_BITS-1:0]           cls_off_r
);
  import frs_pkg::*;

  localparam int PW = NORM_BITS + COORD_BITS;

  logic signed [NORM_BITS-1:0] norm [PLANE_COUNT][3];
  logic signed [NORM_BITS-1:0] sel_norm [3];
  logic signed [NORM_BITS-1:0] sel_off;
  logic [2:0]                  min_at_lo;
  logic signed [PW-1:0]        cull_prod_nxt [PLANE_COUNT][3];
  logic signed [PW-1:0]        min_prod_nxt [3];
  logic signed [PW-1:0]        max_prod_nxt [3];

  always_comb begin
    sel_norm = '{default: '0};
    sel_off  = '0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      norm[i][0] = planes[i].nx;
      norm[i][1] = planes[i].ny;
      norm[i][2] = planes[i].nz;
      if (ctl.plane_select == SEL_BITS'(i)) begin
        sel_norm[0] = planes[i].nx;
        sel_norm[1] = planes[i].ny;
        sel_norm[2] = planes[i].nz;
        sel_off     = planes[i].off;
      end
    end
    // box cull tests the corner picked by the normal signs, sphere the center
    for (int i = 0; i < PLANE_COUNT; i++) begin
      for (int a = 0; a < 3; a++) begin
        cull_prod_nxt[i][a] = PW'(norm[i][a]) *
          PW'((ctl.cmd == CMD_SPHERE_CULL || !norm[i][a][NORM_BITS-1]) ? lo[a] : hi[a]);
      end
    end
    // per axis extreme product, also right for an inverted box
    for (int a = 0; a < 3; a++) begin
      min_at_lo[a]    = (!sel_norm[a][NORM_BITS-1]) == (lo[a] <= hi[a]);
      min_prod_nxt[a] = PW'(sel_norm[a]) * PW'(min_at_lo[a] ? lo[a] : hi[a]);
      max_prod_nxt[a] = PW'(sel_norm[a]) * PW'(min_at_lo[a] ? hi[a] : lo[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cull_prod_r <= cull_prod_nxt;
      min_prod_r  <= min_prod_nxt;
      max_prod_r  <= max_prod_nxt;
      cls_off_r   <= sel_off;
    end
  end

endmodule

FILE: rtl/core/frs_decide_stage.sv
// ----------------------------------------------------------------------
// frs_decide_stage: distance sums and verdicts
// plane distances against zero or the radius, and the classify band
// ----------------------------------------------------------------------
module frs_decide_stage #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 16
) (
  input  frs_pkg::plane_t                                 planes [PLANE_COUNT],
  input  logic [frs_pkg::COUNT_BITS-1:0]                  used_count,
  input  logic [frs_pkg::TOL_BITS-1:0]                    edge_tol,
  input  frs_pkg::ctl_t                                   ctl,
  input  logic signed [COORD_BITS-1:0]                    radius,
  input  logic signed [frs_pkg::NORM_BITS+COORD_BITS-1:0] cull_prod [PLANE_COUNT][3],
  input  logic signed [frs_pkg::NORM_BITS+COORD_BITS-1:0] min_prod [3],
  input  logic signed [frs_pkg::NORM_BITS+COORD_BITS-1:0] max_prod [3],
  input  logic signed [frs_pkg::NORM_BITS-1:0]            cls_off,
  output logic                                            culled_nxt,
  output frs_pkg::side_t                                  side_nxt
);
  import frs_pkg::*;

  localparam int PW = NORM_BITS + COORD_BITS;
  localparam int OW = NORM_BITS + Q_SHIFT;
  localparam int SW = ((PW > OW) ? PW : OW) + 2;

  logic signed [SW-1:0]   plane_d [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] box_hit;
  logic [PLANE_COUNT-1:0] sph_hit;
  logic signed [SW-1:0]   rad_q;
  logic signed [SW-1:0]   tol_s;
  logic signed [SW-1:0]   cls_off_q;
  logic signed [SW-1:0]   d_min;
  logic signed [SW-1:0]   d_max;
  logic                   behind;
  logic                   front;
  logic                   sel_ok;

  always_comb begin
    rad_q     = SW'(radius) <<< Q_SHIFT;
    tol_s     = SW'(edge_tol);
    cls_off_q = SW'(cls_off) <<< Q_SHIFT;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      plane_d[i] = SW'(cull_prod[i][0]) + SW'(cull_prod[i][1]) + SW'(cull_prod[i][2])
                   - (SW'(planes[i].off) <<< Q_SHIFT);
      box_hit[i] = (COUNT_BITS'(i) < used_count) && !plane_d[i][SW-1];
      sph_hit[i] = (COUNT_BITS'(i) < used_count) && (plane_d[i] > rad_q);
    end
    // nearest and farthest corners bound all eight
    d_min  = SW'(min_prod[0]) + SW'(min_prod[1]) + SW'(min_prod[2]) - cls_off_q;
    d_max  = SW'(max_prod[0]) + SW'(max_prod[1]) + SW'(max_prod[2]) - cls_off_q;
    behind = d_min < -tol_s;
    front  = d_max > tol_s;
    sel_ok = ctl.plane_select < SEL_BITS'(PLANE_COUNT);

    culled_nxt = 1'b0;
    side_nxt   = SIDE_ON;
    unique case (ctl.cmd)
      CMD_BOX_CULL: begin
        culled_nxt = !ctl.shape_null && (|box_hit);
      end
      CMD_SPHERE_CULL: begin
        culled_nxt = !radius[COORD_BITS-1] && (|sph_hit);
      end
      CMD_CLASSIFY: begin
        priority if (!sel_ok || (behind && front)) begin
          side_nxt = SIDE_ON;
        end else if (behind) begin
          side_nxt = SIDE_BEHIND;
        end else if (front) begin
          side_nxt = SIDE_FRONT;
        end else begin
          side_nxt = SIDE_ON;
        end
      end
      default: begin
        culled_nxt = 1'b0;
        side_nxt   = SIDE_ON;
      end
    endcase
  end

endmodule

FILE: rtl/core/frustum_cull_and_classify.sv
// ----------------------------------------------------------------------
// frustum_cull_and_classify: plane cull and box classify engine
// beats pass the input, product and result registers, 1 beat per cycle unless a result is
// held back by out_stall; the per-plane multipliers all work in parallel
// synchronous active-low reset empties the pipeline and loads reset config
// ----------------------------------------------------------------------
`include "frustum_cull_and_classify_defines.svh"

module frustum_cull_and_classify #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  frs_pkg::cmd_t                     in_cmd,
  input  logic                              in_shape_null,
  input  logic signed [COORD_BITS-1:0]      in_first_x,
  input  logic signed [COORD_BITS-1:0]      in_first_y,
  input  logic signed [COORD_BITS-1:0]      in_first_z,
  input  logic signed [COORD_BITS-1:0]      in_second_x,
  input  logic signed [COORD_BITS-1:0]      in_second_y,
  input  logic signed [COORD_BITS-1:0]      in_second_z,
  input  logic signed [COORD_BITS-1:0]      in_sphere_radius,
  input  logic [frs_pkg::SEL_BITS-1:0]      in_plane_select,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_culled,
  output frs_pkg::side_t                    out_side,
  input  logic                              cfg_we,
  input  logic [frs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [frs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import frs_pkg::*;

  localparam int PW = NORM_BITS + COORD_BITS;

  plane_t                  planes [PLANE_COUNT];
  logic [COUNT_BITS-1:0]   used_count;
  logic [TOL_BITS-1:0]     edge_tol;

  logic                    advance;
  logic                    v1_r;
  logic                    v2_r;
  logic                    out_valid_r;
  ctl_t                    ctl1_r;
  ctl_t                    ctl2_r;
  logic signed [COORD_BITS-1:0] lo1_r [3];
  logic signed [COORD_BITS-1:0] hi1_r [3];
  logic signed [COORD_BITS-1:0] rad1_r;
  logic signed [COORD_BITS-1:0] rad2_r;

  logic signed [PW-1:0]        cull_prod [PLANE_COUNT][3];
  logic signed [PW-1:0]        min_prod [3];
  logic signed [PW-1:0]        max_prod [3];
  logic signed [NORM_BITS-1:0] cls_off;

  logic                    culled_nxt;
  side_t                   side_nxt;
  logic                    out_culled_r;
  side_t                   out_side_r;

  frs_cfg_regs #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .planes     (planes),
    .used_count (used_count),
    .edge_tol   (edge_tol)
  );

  // whole pipeline moves unless a finished result is held back
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ctl1_r.cmd          <= in_cmd;
      ctl1_r.shape_null   <= in_shape_null;
      ctl1_r.plane_select <= in_plane_select;
      lo1_r[0]            <= in_first_x;
      lo1_r[1]            <= in_first_y;
      lo1_r[2]            <= in_first_z;
      hi1_r[0]            <= in_second_x;
      hi1_r[1]            <= in_second_y;
      hi1_r[2]            <= in_second_z;
      rad1_r              <= in_sphere_radius;
      ctl2_r              <= ctl1_r;
      rad2_r              <= rad1_r;
      out_culled_r        <= culled_nxt;
      out_side_r          <= side_nxt;
    end
  end

  frs_product_stage #(
    .PLANE_COUNT (PLANE_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_product (
    .clk         (clk),
    .advance     (advance),
    .planes      (planes),
    .ctl         (ctl1_r),
    .lo          (lo1_r),
    .hi          (hi1_r),
    .cull_prod_r (cull_prod),
    .min_prod_r  (min_prod),
    .max_prod_r  (max_prod),
    .cls_off_r   (cls_off)
  );

  frs_decide_stage #(
    .PLANE_COUNT (PLANE_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_decide (
    .planes     (planes),
    .used_count (used_count),
    .edge_tol   (edge_tol),
    .ctl        (ctl2_r),
    .radius     (rad2_r),
    .cull_prod  (cull_prod),
    .min_prod   (min_prod),
    .max_prod   (max_prod),
    .cls_off    (cls_off),
    .culled_nxt (culled_nxt),
    .side_nxt   (side_nxt)
  );

  assign out_valid  = out_valid_r;
  assign out_culled = out_culled_r;
  assign out_side   = out_side_r;

  `FRS_ASSERT_IMP(a_hold_on_stall, out_valid_r && out_stall, in_stall, "pipeline moved under stall")
  `FRS_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, v1_r, "accepted beat lost")
  `FRS_ASSERT_IMP(a_cull_or_side, out_valid_r, !(out_culled_r && out_side_r != SIDE_ON), "cull and side both set")
  `FRS_ASSERT_IMP(a_used_clamp, 1'b1, used_count <= COUNT_BITS'(PLANE_COUNT), "plane count not clamped")

endmodule
